>>> hw/rtl/chained_hash_map_engine_macros.svh
// assertion macros for the hash map engine
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH

// condition holds at every clock edge out of reset
`define CHM_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("hash map invariant violated");

// condition in one cycle implies result in the next
`define CHM_CHECK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hash map sequence violated");

`endif

>>> hw/rtl/chm_pkg.sv
// types, constants and helpers shared by the hash map engine
package chm_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int MIN_SLOTS = 8;
  localparam int KEY_BITS  = 32;
  localparam int VAL_W     = 32;
  localparam int OP_W      = 3;
  localparam int ADDR_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = ADDR_W + 1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam cnt_t MIN_CNT = CNT_W'(MIN_SLOTS);
  localparam cnt_t MAX_CNT = CNT_W'(MAX_SLOTS);

  typedef enum logic [OP_W-1:0] {
    OP_GET   = 3'd0,
    OP_SET   = 3'd1,
    OP_DEL   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_SCAN  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_F_HEAD, S_F_TEST, S_F_SLOT,
    S_D_LINK, S_D_FREE, S_D_HALF,
    S_INS_CHK, S_INS, S_INS_D,
    S_RS_HINIT, S_RS_CRD, S_RS_CUSE, S_RS_CWR, S_RS_FREE,
    S_SC_RD, S_SC_CHK, S_FIN
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [VAL_W-1:0]    value;
    logic                used;
    cnt_t                link;
  } slot_ent_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_BITS-1:0] key;
    logic [VAL_W-1:0]    value;
    cnt_t                index;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [VAL_W-1:0]    value_out;
    logic [KEY_BITS-1:0] key_out;
    cnt_t                slot;
    cnt_t                entry_total;
    cnt_t                size_now;
  } rsp_t;

  // size is a power of two, so the bucket is the low key bits
  function automatic addr_t bucket_of(logic [KEY_BITS-1:0] k, cnt_t size);
    addr_t mask;
    mask = size[ADDR_W-1:0] - addr_t'(1);
    return k[ADDR_W-1:0] & mask;
  endfunction

endpackage

>>> hw/rtl/chm_req_if.sv
// request channel of the hash map engine
interface chm_req_if;
  import chm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [KEY_BITS-1:0] key;
  logic [VAL_W-1:0]           value;
  logic [CNT_W-1:0]           index;

  modport source (output valid, op, key, value, index, input ready);
  modport sink   (input valid, op, key, value, index, output ready);
endinterface

>>> hw/rtl/chm_rsp_if.sv
// result channel of the hash map engine
interface chm_rsp_if;
  import chm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic                       found;
  logic [VAL_W-1:0]           value_out;
  logic signed [KEY_BITS-1:0] key_out;
  logic [CNT_W-1:0]           slot;
  logic [CNT_W-1:0]           entry_total;
  logic [CNT_W-1:0]           size_now;

  modport source (output valid, status, found, value_out, key_out, slot, entry_total,
                  size_now, input ready);
  modport sink   (input valid, status, found, value_out, key_out, slot, entry_total,
                  size_now, output ready);
endinterface

>>> hw/rtl/chm_ram.sv
// generic simple dual port ram with registered read
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/chm_ctrl.sv
// sequencer for lookups, updates, scans and resizes of the hash map
`include "chained_hash_map_engine_macros.svh"
module chm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  chm_pkg::req_t     req,
  output logic              res_valid,
  input  logic              res_take,
  output chm_pkg::rsp_t     res,
  output logic              s_we,
  output chm_pkg::addr_t    s_waddr,
  output chm_pkg::slot_ent_t s_wdata,
  output chm_pkg::addr_t    s_raddr,
  input  chm_pkg::slot_ent_t s_ent,
  output logic              b_we,
  output chm_pkg::addr_t    b_waddr,
  output chm_pkg::cnt_t     b_wdata,
  output chm_pkg::addr_t    b_raddr,
  input  chm_pkg::cnt_t     b_rdata
);
  import chm_pkg::*;

  state_t              state, state_next;
  logic [OP_W-1:0]     op_r, op_next;
  logic [KEY_BITS-1:0] key_r, key_next;
  logic [VAL_W-1:0]    val_r, val_next;
  cnt_t                idx_r, idx_next;
  cnt_t                prev_r, prev_next;
  slot_ent_t           prev_ent, prev_ent_next;
  slot_ent_t           cur_ent, cur_ent_next;
  cnt_t                table_size, table_size_next;
  cnt_t                entry_count, entry_count_next;
  cnt_t                free_head, free_head_next;
  cnt_t                ns_r, ns_next;
  cnt_t                i_r, i_next;
  cnt_t                n_r, n_next;
  cnt_t                j_r, j_next;
  rsp_t                res_r, res_next;
  addr_t               h_key;
  addr_t               h_rs;
  cnt_t                cnt_dec;

  assign h_key   = bucket_of(key_r, table_size);
  assign h_rs    = bucket_of(cur_ent.key, ns_r);
  assign cnt_dec = entry_count - cnt_t'(1);

  always_comb begin
    res             = res_r;
    res.entry_total = entry_count;
    res.size_now    = table_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      table_size  <= '0;
      entry_count <= '0;
      free_head   <= '0;
    end else begin
      state       <= state_next;
      table_size  <= table_size_next;
      entry_count <= entry_count_next;
      free_head   <= free_head_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_next;
    key_r    <= key_next;
    val_r    <= val_next;
    idx_r    <= idx_next;
    prev_r   <= prev_next;
    prev_ent <= prev_ent_next;
    cur_ent  <= cur_ent_next;
    ns_r     <= ns_next;
    i_r      <= i_next;
    n_r      <= n_next;
    j_r      <= j_next;
    res_r    <= res_next;
  end

  always_comb begin
    state_next       = state;
    op_next          = op_r;
    key_next         = key_r;
    val_next         = val_r;
    idx_next         = idx_r;
    prev_next        = prev_r;
    prev_ent_next    = prev_ent;
    cur_ent_next     = cur_ent;
    table_size_next  = table_size;
    entry_count_next = entry_count;
    free_head_next   = free_head;
    ns_next          = ns_r;
    i_next           = i_r;
    n_next           = n_r;
    j_next           = j_r;
    res_next         = res_r;
    req_ready        = 1'b0;
    res_valid        = 1'b0;
    s_we             = 1'b0;
    s_waddr          = '0;
    s_wdata          = '0;
    s_raddr          = '0;
    b_we             = 1'b0;
    b_waddr          = '0;
    b_wdata          = '0;
    b_raddr          = '0;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_next    = req.op;
          key_next   = req.key;
          val_next   = req.value;
          idx_next   = req.index;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_next        = '0;
        res_next.status = ST_OK;
        res_next.slot   = table_size;
        prev_next       = table_size;
        b_raddr         = h_key;
        case (op_t'(op_r))
          OP_GET, OP_DEL: begin
            if (table_size == '0 || entry_count == '0) begin
              res_next.status = ST_NOT_FOUND;
              state_next      = S_FIN;
            end else begin
              state_next = S_F_HEAD;
            end
          end
          OP_SET: begin
            state_next = (table_size == '0) ? S_INS_CHK : S_F_HEAD;
          end
          OP_CLEAR: begin
            table_size_next  = '0;
            entry_count_next = '0;
            free_head_next   = '0;
            res_next.slot    = '0;
            state_next       = S_FIN;
          end
          OP_SCAN: begin
            if (idx_r > table_size) begin
              res_next.status = ST_RANGE;
              state_next      = S_FIN;
            end else begin
              state_next = S_SC_RD;
            end
          end
          default: state_next = S_FIN;
        endcase
      end

      S_F_HEAD: begin
        idx_next   = b_rdata;
        state_next = S_F_TEST;
      end

      S_F_TEST: begin
        if (idx_r >= table_size) begin
          if (op_t'(op_r) == OP_SET) begin
            state_next = S_INS_CHK;
          end else begin
            res_next.status = ST_NOT_FOUND;
            state_next      = S_FIN;
          end
        end else begin
          s_raddr    = idx_r[ADDR_W-1:0];
          state_next = S_F_SLOT;
        end
      end

      S_F_SLOT: begin
        cur_ent_next = s_ent;
        if (s_ent.used && s_ent.key == key_r) begin
          res_next.found   = 1'b1;
          res_next.key_out = key_r;
          res_next.slot    = idx_r;
          case (op_t'(op_r))
            OP_GET: begin
              res_next.value_out = s_ent.value;
              state_next         = S_FIN;
            end
            OP_SET: begin
              s_we               = 1'b1;
              s_waddr            = idx_r[ADDR_W-1:0];
              s_wdata            = s_ent;
              s_wdata.value      = val_r;
              res_next.value_out = val_r;
              state_next         = S_FIN;
            end
            default: begin
              res_next.value_out = s_ent.value;
              state_next         = S_D_LINK;
            end
          endcase
        end else begin
          prev_next     = idx_r;
          prev_ent_next = s_ent;
          idx_next      = s_ent.link;
          state_next    = S_F_TEST;
        end
      end

      S_D_LINK: begin
        if (prev_r < table_size) begin
          s_we         = 1'b1;
          s_waddr      = prev_r[ADDR_W-1:0];
          s_wdata      = prev_ent;
          s_wdata.link = cur_ent.link;
        end else begin
          b_we    = 1'b1;
          b_waddr = h_key;
          b_wdata = cur_ent.link;
        end
        state_next = S_D_FREE;
      end

      S_D_FREE: begin
        s_we             = 1'b1;
        s_waddr          = idx_r[ADDR_W-1:0];
        s_wdata.key      = cur_ent.key;
        s_wdata.value    = '0;
        s_wdata.used     = 1'b0;
        s_wdata.link     = free_head;
        free_head_next   = idx_r;
        entry_count_next = cnt_dec;
        if (table_size > MIN_CNT && (table_size >> 2) >= cnt_dec) begin
          ns_next    = table_size;
          state_next = S_D_HALF;
        end else begin
          state_next = S_FIN;
        end
      end

      S_D_HALF: begin
        ns_next = ns_r >> 1;
        if (!((ns_r >> 1) > MIN_CNT && (ns_r >> 3) >= entry_count)) begin
          j_next     = '0;
          i_next     = '0;
          n_next     = '0;
          state_next = S_RS_HINIT;
        end
      end

      S_INS_CHK: begin
        if (entry_count >= table_size) begin
          if (table_size == MAX_CNT) begin
            res_next.status = ST_FULL;
            state_next      = S_FIN;
          end else begin
            ns_next    = (table_size == '0) ? MIN_CNT : (table_size << 1);
            j_next     = '0;
            i_next     = '0;
            n_next     = '0;
            state_next = S_RS_HINIT;
          end
        end else begin
          state_next = S_INS;
        end
      end

      S_INS: begin
        if (free_head >= table_size) begin
          res_next.status = ST_FULL;
          res_next.slot   = table_size;
          state_next      = S_FIN;
        end else begin
          s_raddr    = free_head[ADDR_W-1:0];
          b_raddr    = h_key;
          state_next = S_INS_D;
        end
      end

      S_INS_D: begin
        s_we               = 1'b1;
        s_waddr            = free_head[ADDR_W-1:0];
        s_wdata.key        = key_r;
        s_wdata.value      = val_r;
        s_wdata.used       = 1'b1;
        s_wdata.link       = b_rdata;
        b_we               = 1'b1;
        b_waddr            = h_key;
        b_wdata            = free_head;
        free_head_next     = s_ent.link;
        entry_count_next   = entry_count + cnt_t'(1);
        res_next.status    = ST_OK;
        res_next.found     = 1'b0;
        res_next.value_out = val_r;
        res_next.key_out   = key_r;
        res_next.slot      = free_head;
        state_next         = S_FIN;
      end

      S_RS_HINIT: begin
        if (j_r < ns_r) begin
          b_we    = 1'b1;
          b_waddr = j_r[ADDR_W-1:0];
          b_wdata = ns_r;
          j_next  = j_r + cnt_t'(1);
        end else begin
          j_next     = '0;
          state_next = (table_size == '0) ? S_RS_FREE : S_RS_CRD;
        end
      end

      S_RS_CRD: begin
        s_raddr    = i_r[ADDR_W-1:0];
        state_next = S_RS_CUSE;
      end

      S_RS_CUSE: begin
        cur_ent_next = s_ent;
        if (s_ent.used) begin
          b_raddr    = bucket_of(s_ent.key, ns_r);
          state_next = S_RS_CWR;
        end else begin
          i_next = i_r + cnt_t'(1);
          if ((i_r + cnt_t'(1)) == table_size) begin
            j_next     = n_r;
            state_next = S_RS_FREE;
          end else begin
            state_next = S_RS_CRD;
          end
        end
      end

      S_RS_CWR: begin
        s_we          = 1'b1;
        s_waddr       = n_r[ADDR_W-1:0];
        s_wdata.key   = cur_ent.key;
        s_wdata.value = cur_ent.value;
        s_wdata.used  = 1'b1;
        s_wdata.link  = b_rdata;
        b_we          = 1'b1;
        b_waddr       = h_rs;
        b_wdata       = n_r;
        n_next        = n_r + cnt_t'(1);
        i_next        = i_r + cnt_t'(1);
        if ((i_r + cnt_t'(1)) == table_size) begin
          j_next     = n_r + cnt_t'(1);
          state_next = S_RS_FREE;
        end else begin
          state_next = S_RS_CRD;
        end
      end

      S_RS_FREE: begin
        if (j_r < ns_r) begin
          s_we         = 1'b1;
          s_waddr      = j_r[ADDR_W-1:0];
          s_wdata.used = 1'b0;
          s_wdata.link = j_r + cnt_t'(1);
          j_next       = j_r + cnt_t'(1);
        end else begin
          free_head_next  = n_r;
          table_size_next = ns_r;
          state_next      = (op_t'(op_r) == OP_SET) ? S_INS : S_FIN;
        end
      end

      S_SC_RD: begin
        if (idx_r >= table_size) begin
          state_next = S_FIN;
        end else begin
          s_raddr    = idx_r[ADDR_W-1:0];
          state_next = S_SC_CHK;
        end
      end

      S_SC_CHK: begin
        if (s_ent.used) begin
          res_next.found     = 1'b1;
          res_next.value_out = s_ent.value;
          res_next.key_out   = s_ent.key;
          res_next.slot      = idx_r;
          state_next         = S_FIN;
        end else begin
          idx_next   = idx_r + cnt_t'(1);
          state_next = S_SC_RD;
        end
      end

      S_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  `CHM_CHECK(a_count_fits, entry_count <= table_size)
  `CHM_CHECK(a_size_shape, $onehot0(table_size) && (table_size == '0 || table_size >= MIN_CNT))
  `CHM_CHECK(a_free_fits, free_head <= table_size)
  `CHM_CHECK_NEXT(a_insert_counts, state == S_INS_D,
                  entry_count == cnt_t'($past(entry_count) + cnt_t'(1)))
endmodule

>>> hw/rtl/chained_hash_map_engine.sv
// top level of the chained hash map engine
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, key, value, index
//   rsp      out  valid/ready   status, found, value_out, key_out, slot,
//                               entry_total, size_now
//
// one item at a time; get and set walk the bucket chain, a set that misses then
// inserts, a delete then unlinks and frees the slot, and a scan passes over
// free slots until it finds a used one
// a resize writes every bucket head of the new size, compacts the old slots and
// rebuilds chains, then relinks the free list
// synchronous reset clears state, size, count, free head and output valid; no clearing pass
// the result register lets the next item in while a result waits on rsp
module chained_hash_map_engine (
  input  logic       clk,
  input  logic       rst,
  chm_req_if.sink    req,
  chm_rsp_if.source  rsp
);
  import chm_pkg::*;

  req_t      req_d;
  rsp_t      res;
  rsp_t      out_r;
  logic      out_valid;
  logic      res_valid;
  logic      res_take;
  logic      s_we;
  addr_t     s_waddr;
  slot_ent_t s_wdata;
  addr_t     s_raddr;
  slot_ent_t s_rdata;
  logic      b_we;
  addr_t     b_waddr;
  cnt_t      b_wdata;
  addr_t     b_raddr;
  cnt_t      b_rdata;

  assign req_d.op    = req.op;
  assign req_d.key   = req.key;
  assign req_d.value = req.value;
  assign req_d.index = req.index;

  assign res_take = !out_valid || rsp.ready;

  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req       (req_d),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .s_we      (s_we),
    .s_waddr   (s_waddr),
    .s_wdata   (s_wdata),
    .s_raddr   (s_raddr),
    .s_ent     (s_rdata),
    .b_we      (b_we),
    .b_waddr   (b_waddr),
    .b_wdata   (b_wdata),
    .b_raddr   (b_raddr),
    .b_rdata   (b_rdata)
  );

  chm_ram #(.WIDTH($bits(slot_ent_t)), .DEPTH(MAX_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  chm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SLOTS)) u_bucket_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_r.status;
  assign rsp.found       = out_r.found;
  assign rsp.value_out   = out_r.value_out;
  assign rsp.key_out     = out_r.key_out;
  assign rsp.slot        = out_r.slot;
  assign rsp.entry_total = out_r.entry_total;
  assign rsp.size_now    = out_r.size_now;
endmodule

>>> tb/sv/chm_scoreboard.sv
// checker for the hash map engine: predicts every result and compares it field by field
module chm_scoreboard (
  input  logic  clk,
  input  logic  rst,
  chm_req_if    req,
  chm_rsp_if    rsp,
  output int    errors,
  output int    pending
);
  import chm_pkg::*;

  logic [31:0] map_key [MAX_SLOTS];
  logic [31:0] map_val [MAX_SLOTS];
  bit          map_used [MAX_SLOTS];
  int          map_link [MAX_SLOTS];
  int          map_head [MAX_SLOTS];
  int          free_top;
  int          entries;
  int          size;
  rsp_t        expected_rsp [$];

  function automatic int bucket_idx(logic [31:0] k, int sz);
    return int'(k[9:0]) % sz;
  endfunction

  function automatic int chain_find(logic [31:0] k, output int prev);
    int idx;
    int steps;
    prev = size;
    steps = 0;
    if (size == 0) begin
      prev = 0;
      return 0;
    end
    idx = map_head[bucket_idx(k, size)];
    while (idx < size && steps <= size) begin
      if (map_used[idx] && map_key[idx] == k) break;
      prev = idx;
      idx = map_link[idx];
      steps++;
    end
    if (idx > size || steps > size) idx = size;
    return idx;
  endfunction

  function automatic void compact_to(int nsize);
    int n;
    int h;
    n = 0;
    for (int i = 0; i < size; i++) begin
      if (map_used[i]) begin
        map_key[n] = map_key[i];
        map_val[n] = map_val[i];
        n++;
      end
    end
    if (n > nsize) n = nsize;
    for (int i = 0; i < nsize; i++) map_head[i] = nsize;
    for (int i = 0; i < n; i++) begin
      h = bucket_idx(map_key[i], nsize);
      map_link[i] = map_head[h];
      map_head[h] = i;
      map_used[i] = 1;
    end
    for (int i = n; i < MAX_SLOTS; i++) map_used[i] = 0;
    for (int i = n; i < nsize; i++) map_link[i] = i + 1;
    free_top = n;
    size = nsize;
  endfunction

  function automatic rsp_t apply_request(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                                         int start);
    rsp_t r;
    int idx;
    int prev;
    int nsize;
    int f;
    int h;
    bit ok;
    r = '0;
    r.status = ST_OK;
    r.slot = cnt_t'(size);
    case (op)
      OP_GET: begin
        idx = chain_find(k, prev);
        if (size != 0 && entries != 0 && idx < size) begin
          r.found = 1; r.value_out = map_val[idx]; r.key_out = k; r.slot = cnt_t'(idx);
        end else r.status = ST_NOT_FOUND;
      end
      OP_SET: begin
        idx = chain_find(k, prev);
        if (size != 0 && idx < size) begin
          map_val[idx] = v;
          r.found = 1; r.value_out = v; r.key_out = k; r.slot = cnt_t'(idx);
        end else begin
          nsize = size;
          ok = 1;
          if (entries + 1 > size) begin
            nsize = size != 0 ? size * 2 : MIN_SLOTS;
            if (nsize > MAX_SLOTS) ok = 0;
          end
          if (ok && nsize != size) compact_to(nsize);
          if (ok && free_top >= size) ok = 0;
          if (!ok) r.status = ST_FULL;
          else begin
            f = free_top;
            free_top = map_link[f];
            h = bucket_idx(k, size);
            map_key[f] = k;
            map_val[f] = v;
            map_used[f] = 1;
            map_link[f] = map_head[h];
            map_head[h] = f;
            entries++;
            r.value_out = v; r.key_out = k; r.slot = cnt_t'(f);
          end
        end
      end
      OP_DEL: begin
        idx = chain_find(k, prev);
        if (size == 0 || entries == 0 || idx >= size) r.status = ST_NOT_FOUND;
        else begin
          if (prev < size) map_link[prev] = map_link[idx];
          else map_head[bucket_idx(k, size)] = map_link[idx];
          r.found = 1; r.value_out = map_val[idx]; r.key_out = k; r.slot = cnt_t'(idx);
          map_used[idx] = 0;
          map_val[idx] = '0;
          map_link[idx] = free_top;
          free_top = idx;
          entries--;
          if (size > MIN_SLOTS && size / 4 >= entries) begin
            nsize = size;
            do nsize /= 2; while (nsize > MIN_SLOTS && nsize / 4 >= entries);
            compact_to(nsize);
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_SLOTS; i++) map_used[i] = 0;
        size = 0; entries = 0; free_top = 0;
        r.slot = '0;
      end
      OP_SCAN: begin
        if (start > size) r.status = ST_RANGE;
        else begin
          idx = start;
          while (idx < size && !map_used[idx]) idx++;
          if (idx < size) begin
            r.found = 1; r.value_out = map_val[idx]; r.key_out = map_key[idx];
            r.slot = cnt_t'(idx);
          end
        end
      end
      default: ;
    endcase
    r.entry_total = cnt_t'(entries);
    r.size_now = cnt_t'(size);
    return r;
  endfunction

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      errors <= 0;
      free_top = 0;
      entries = 0;
      size = 0;
      for (int i = 0; i < MAX_SLOTS; i++) map_used[i] = 0;
    end else begin
      if (req.valid && req.ready)
        expected_rsp.push_back(apply_request(req.op, req.key, req.value, int'(req.index)));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no item outstanding");
          errors <= errors + 1;
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.status != e.status ||
              rsp.found != e.found ||
              rsp.value_out != e.value_out ||
              rsp.key_out != e.key_out ||
              rsp.slot != e.slot ||
              rsp.entry_total != e.entry_total ||
              rsp.size_now != e.size_now)
            errors <= errors + 1;
          if (rsp.status != e.status)
            $error("status expected %0d got %0d", e.status, rsp.status);
          if (rsp.found != e.found)
            $error("found expected %0d got %0d", e.found, rsp.found);
          if (rsp.value_out != e.value_out)
            $error("value_out expected %h got %h", e.value_out, rsp.value_out);
          if (rsp.key_out != e.key_out)
            $error("key_out expected %h got %h", e.key_out, rsp.key_out);
          if (rsp.slot != e.slot)
            $error("slot expected %0d got %0d", e.slot, rsp.slot);
          if (rsp.entry_total != e.entry_total)
            $error("entry_total expected %0d got %0d", e.entry_total, rsp.entry_total);
          if (rsp.size_now != e.size_now)
            $error("size_now expected %0d got %0d", e.size_now, rsp.size_now);
        end
      end
    end
  end

endmodule

>>> tb/sv/tb.sv
// testbench top for the hash map engine: stimulus, stalls and the final verdict
module tb;
  import chm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 0;
  logic rst = 1;
  bit   steady = 0;
  int   errors;
  int   pending;
  int   cycles = 0;
  logic [31:0] key_pool [48];

  chm_req_if req ();
  chm_rsp_if rsp ();

  chained_hash_map_engine dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  chm_scoreboard chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                      .errors(errors), .pending(pending));

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= steady || ($urandom_range(0, 99) >= 29);
  end

  task automatic send_item(logic [2:0] op, logic [31:0] k, logic [31:0] v, logic [10:0] ix);
    while (!steady && $urandom_range(0, 99) < 29) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.key   <= k;
    req.value <= v;
    req.index <= ix;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [31:0] k;
    pick = $urandom_range(0, 99);
    k = ($urandom_range(0, 19) == 0) ? $urandom() : key_pool[$urandom_range(0, 47)];
    if (pick < 36) send_item(OP_SET, k, $urandom(), 11'($urandom()));
    else if (pick < 60) send_item(OP_GET, k, $urandom(), 11'($urandom()));
    else if (pick < 85) send_item(OP_DEL, k, $urandom(), 11'($urandom()));
    else if (pick < 94)
      send_item(OP_SCAN, $urandom(), $urandom(),
                ($urandom_range(0, 9) == 0) ? 11'($urandom()) : 11'($urandom_range(0, 33)));
    else if (pick < 96) send_item(OP_CLEAR, $urandom(), $urandom(), 11'($urandom()));
    else send_item(3'($urandom_range(OP_SCAN + 1, 7)), $urandom(), $urandom(),
                   11'($urandom()));
  endtask

  initial begin
    req.valid <= 1'b0;
    req.op    <= OP_GET;
    req.key   <= '0;
    req.value <= '0;
    req.index <= '0;
    for (int i = 0; i < 48; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty map: misses, scans, ignored ops; then sets, a get, range scans, deletes, a clear
    send_item(OP_GET, 32'h8000_0000, '0, '0);
    send_item(OP_DEL, 32'h7fff_ffff, '0, '0);
    send_item(OP_SCAN, '0, '0, 11'd0);
    send_item(OP_SCAN, '0, '0, 11'd1);
    send_item(3'd7, '1, '1, '1);
    send_item(OP_SET, 32'h8000_0000, 32'hffff_ffff, '0);
    send_item(OP_SET, 32'h7fff_ffff, 32'h0, '0);
    send_item(OP_SET, 32'hffff_ffff, 32'h1234_5678, '0);
    send_item(OP_SET, 32'h7fff_ffff, 32'hdead_beef, '0);
    send_item(OP_GET, 32'hffff_ffff, '0, '0);
    send_item(OP_SCAN, '0, '0, 11'd1);
    send_item(OP_SCAN, '0, '0, 11'd8);
    send_item(OP_SCAN, '0, '0, 11'd9);
    send_item(OP_SCAN, '0, '0, 11'h7ff);
    send_item(OP_DEL, 32'h8000_0000, '0, '0);
    send_item(OP_DEL, 32'h8000_0000, '0, '0);
    send_item(3'd5, '0, '0, '0);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_GET, 32'hffff_ffff, '0, '0);

    // fill to the largest size, then one more insert is refused; then scans and deletes
    steady = 1;
    for (int i = 0; i < MAX_SLOTS; i++) send_item(OP_SET, i * 3, $urandom(), '0);
    send_item(OP_SET, 32'hffff_fff0, $urandom(), '0);
    send_item(OP_SET, 32'd9, 32'h5a5a_5a5a, '0);
    send_item(OP_SCAN, '0, '0, 11'd1023);
    send_item(OP_SCAN, '0, '0, 11'd1024);
    send_item(OP_SCAN, '0, '0, 11'd1025);
    for (int i = 0; i < 1000; i++) send_item(OP_DEL, i * 3, '0, '0);
    steady = 0;
    send_item(OP_SCAN, '0, '0, 11'd0);
    send_item(OP_CLEAR, '0, '0, '0);

    for (int n = 0; n < 600; n++) begin
      steady = (n >= 250 && n < 400);
      random_item();
    end
    steady = 0;
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
